// ===== rtl/lext_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lext_pkg;

    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int POSITION_BITS_DEF = 16;

    // depth of the result queue; the input side needs two free slots
    localparam int QUEUE_DEPTH = 4;

    // extremum kind codes
    localparam logic KIND_MAX = 1'b0;
    localparam logic KIND_MIN = 1'b1;

    // sequence phase codes
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_RUN    = 2'd2;

    // results produced by one accepted sample
    typedef struct packed {
        logic first;   // slot 0 holds a result
        logic second;  // slot 1 holds a result (final one after a turn)
    } push_t;

endpackage : lext_pkg

`default_nettype wire

// ===== rtl/lext_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lext_core
    import lext_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_fire,
    input  wire logic signed [SAMPLE_BITS-1:0]   sample,
    input  wire logic                            last_sample,
    output push_t                                push,
    output logic                                 res_kind  [2],
    output logic signed [SAMPLE_BITS-1:0]        res_value [2],
    output logic        [POSITION_BITS-1:0]      res_pos   [2],
    output logic                                 res_end   [2]
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    logic signed [SAMPLE_BITS-1:0]   held_value_reg, held_value_next;
    logic        [POSITION_BITS-1:0] held_pos_reg, held_pos_next;
    logic                            rising_reg, rising_next;
    logic        [POSITION_BITS-1:0] count_reg, count_next;
    logic        [1:0]               phase_reg, phase_next;

    logic signed [SAMPLE_BITS-1:0]   upd_value;
    logic        [POSITION_BITS-1:0] upd_pos;
    logic                            dir;
    logic                            upd_rising;
    logic                            turn;
    logic                            higher;
    logic                            lower;

    assign higher = (sample > held_value_reg);
    assign lower  = (sample < held_value_reg);

    always_comb
    begin
        upd_value  = held_value_reg;
        upd_pos    = held_pos_reg;
        turn       = 1'b0;
        dir        = (phase_reg == PH_SECOND) ? !lower : rising_reg;
        upd_rising = dir;
        // follow the running top or bottom, turn on a strict reversal
        if ((dir && higher) || (!dir && lower))
        begin
            upd_value = sample;
            upd_pos   = count_reg;
        end
        else if ((dir && lower) || (!dir && higher))
        begin
            turn       = 1'b1;
            upd_value  = sample;
            upd_pos    = count_reg;
            upd_rising = !dir;
        end
    end

    always_comb
    begin
        held_value_next = held_value_reg;
        held_pos_next   = held_pos_reg;
        rising_next     = rising_reg;
        phase_next      = phase_reg;
        count_next      = (count_reg == POS_MAX) ? count_reg : count_reg + 1'b1;
        push            = '0;
        res_kind[0]     = KIND_MAX;
        res_value[0]    = held_value_reg;
        res_pos[0]      = held_pos_reg;
        res_end[0]      = 1'b0;
        res_kind[1]     = upd_rising ? KIND_MAX : KIND_MIN;
        res_value[1]    = upd_value;
        res_pos[1]      = upd_pos;
        res_end[1]      = 1'b1;

        if (!in_fire)
        begin
            count_next = count_reg;
        end
        else if (phase_reg == PH_FIRST)
        begin
            held_value_next = sample;
            held_pos_next   = count_reg;
            phase_next      = PH_SECOND;
            if (last_sample)
            begin
                push.first   = 1'b1;
                res_kind[0]  = KIND_MAX;
                res_value[0] = sample;
                res_pos[0]   = count_reg;
                res_end[0]   = 1'b1;
            end
        end
        else
        begin
            held_value_next = upd_value;
            held_pos_next   = upd_pos;
            rising_next     = upd_rising;
            phase_next      = PH_RUN;
            if (turn)
            begin
                push.first  = 1'b1;
                res_kind[0] = dir ? KIND_MAX : KIND_MIN;
                push.second = last_sample;
            end
            else if (last_sample)
            begin
                push.first   = 1'b1;
                res_kind[0]  = res_kind[1];
                res_value[0] = upd_value;
                res_pos[0]   = upd_pos;
                res_end[0]   = 1'b1;
            end
        end

        // drop all state at the end of a sequence
        if (in_fire && last_sample)
        begin
            held_value_next = '0;
            held_pos_next   = '0;
            rising_next     = 1'b1;
            count_next      = '0;
            phase_next      = PH_FIRST;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_value_reg <= '0;
            held_pos_reg   <= '0;
            rising_reg     <= 1'b1;
            count_reg      <= '0;
            phase_reg      <= PH_FIRST;
        end
        else
        begin
            held_value_reg <= held_value_next;
            held_pos_reg   <= held_pos_next;
            rising_reg     <= rising_next;
            count_reg      <= count_next;
            phase_reg      <= phase_next;
        end
    end

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && last_sample |=> phase_reg == PH_FIRST && count_reg == '0)
        else $error("state not cleared after last sample");

    a_second_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        push.second |-> push.first && !res_end[0] && res_end[1])
        else $error("two results without a turn followed by the final one");

    a_push_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
        push.first |-> in_fire)
        else $error("result produced without an input beat");

endmodule : lext_core

`default_nettype wire

// ===== rtl/lext_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lext_queue
    import lext_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire push_t                           push,
    input  wire logic                            res_kind  [2],
    input  wire logic signed [SAMPLE_BITS-1:0]   res_value [2],
    input  wire logic        [POSITION_BITS-1:0] res_pos   [2],
    input  wire logic                            res_end   [2],
    output logic                                 space_ok,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 extremum_kind,
    output logic signed [SAMPLE_BITS-1:0]        extremum_value,
    output logic        [POSITION_BITS-1:0]      extremum_position,
    output logic                                 sequence_end
);

    localparam int ENTRY_BITS = SAMPLE_BITS + POSITION_BITS + 2;
    localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL  = CNT_BITS'(QUEUE_DEPTH);
    localparam logic [CNT_BITS-1:0] CNT_LIMIT = CNT_BITS'(QUEUE_DEPTH - 2);

    logic [ENTRY_BITS-1:0] mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [ENTRY_BITS-1:0] entry0, entry1, head;
    logic                  pop;
    logic [PTR_BITS-1:0]   wr_ptr_b;

    assign entry0   = {res_kind[0], res_value[0], res_pos[0], res_end[0]};
    assign entry1   = {res_kind[1], res_value[1], res_pos[1], res_end[1]};
    assign wr_ptr_b = wr_ptr_reg + 1'b1;
    assign pop      = out_valid && out_ready;

    assign space_ok  = (count_reg <= CNT_LIMIT);
    assign out_valid = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    assign extremum_kind     = head[ENTRY_BITS-1];
    assign extremum_value    = head[ENTRY_BITS-2 -: SAMPLE_BITS];
    assign extremum_position = head[POSITION_BITS:1];
    assign sequence_end      = head[0];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (push.second)
        begin
            wr_ptr_next = wr_ptr_reg + 2'(2);
        end
        else if (push.first)
        begin
            wr_ptr_next = wr_ptr_b;
        end
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_BITS'(push.first) + CNT_BITS'(push.second)
                      - CNT_BITS'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            mem[wr_ptr_reg] <= entry0;
        end
        if (push.second)
        begin
            mem[wr_ptr_b] <= entry1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.first |-> space_ok)
        else $error("push into result queue without two free slots");

    a_ptr_distance: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != CNT_FULL |-> PTR_BITS'(wr_ptr_reg - rd_ptr_reg)
                                  == PTR_BITS'(count_reg))
        else $error("queue pointers disagree with fill count");

endmodule : lext_queue

`default_nettype wire

// ===== rtl/local_extrema_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_ready  sample, last_sample
// out      output     out_valid/out_ready  extremum_kind, extremum_value,
//                                          extremum_position, sequence_end
//
// One sample per cycle while in_ready is high: compares and state update sit
// between the input port and a four-entry result queue.
// A sample yields zero, one or two results; in_ready is high while the
// queue has two free slots, so a stalled output side throttles input.
// Results are registered into the queue when the sample is accepted and leave it in order.
// Reset (rst_n low) empties the queue and returns to awaiting a first sample.

module local_extrema_tracker
    import lext_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]   sample,
    input  wire logic                            last_sample,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 extremum_kind,
    output logic signed [SAMPLE_BITS-1:0]        extremum_value,
    output logic        [POSITION_BITS-1:0]      extremum_position,
    output logic                                 sequence_end
);

    push_t                           push;
    logic                            res_kind  [2];
    logic signed [SAMPLE_BITS-1:0]   res_value [2];
    logic        [POSITION_BITS-1:0] res_pos   [2];
    logic                            res_end   [2];
    logic                            in_fire;

    assign in_fire = in_valid && in_ready;

    lext_core #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .sample      (sample),
        .last_sample (last_sample),
        .push        (push),
        .res_kind    (res_kind),
        .res_value   (res_value),
        .res_pos     (res_pos),
        .res_end     (res_end)
    );

    lext_queue #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_queue (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .res_kind          (res_kind),
        .res_value         (res_value),
        .res_pos           (res_pos),
        .res_end           (res_end),
        .space_ok          (in_ready),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .extremum_kind     (extremum_kind),
        .extremum_value    (extremum_value),
        .extremum_position (extremum_position),
        .sequence_end      (sequence_end)
    );

endmodule : local_extrema_tracker

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import lext_pkg::*;

    localparam int SB = SAMPLE_BITS_DEF;
    localparam int PB = POSITION_BITS_DEF;
    localparam int ITEM_TARGET = 1500;

    typedef logic signed [SB-1:0] sample_t;

    typedef struct packed {
        logic              kind;
        sample_t           value;
        logic [PB-1:0]     position;
        logic              seq_end;
    } extremum_t;

    // Tracks the peak/valley state and holds the extrema still owed by the block.
    class extrema_book;
        sample_t       held_value;
        logic [PB-1:0] held_position;
        logic          rising;
        logic [PB-1:0] next_position;
        logic [1:0]    phase;
        extremum_t     awaited[$];

        function new();
            restart();
        endfunction

        function void restart();
            held_value    = '0;
            held_position = '0;
            rising        = 1'b1;
            next_position = '0;
            phase         = PH_FIRST;
        endfunction

        function void push(logic kind, logic seq_end);
            extremum_t e;
            e.kind     = kind;
            e.value    = held_value;
            e.position = held_position;
            e.seq_end  = seq_end;
            awaited.insert(awaited.size(), e);
        endfunction

        function void note_sample(sample_t s, logic last);
            logic [PB-1:0] pos;
            pos = next_position;
            if (next_position != '1)
                next_position = next_position + 1'b1;

            if (phase == PH_FIRST)
            begin
                held_value    = s;
                held_position = pos;
                phase         = PH_SECOND;
                if (last)
                begin
                    push(KIND_MAX, 1'b1);
                    restart();
                end
                return;
            end

            if (phase == PH_SECOND)
            begin
                rising = (s >= held_value);
                phase  = PH_RUN;
            end

            // a strictly opposite step emits the held sample and turns
            if (rising)
            begin
                if (s > held_value)
                begin
                    held_value    = s;
                    held_position = pos;
                end
                else if (s < held_value)
                begin
                    push(KIND_MAX, 1'b0);
                    held_value    = s;
                    held_position = pos;
                    rising        = 1'b0;
                end
            end
            else
            begin
                if (s < held_value)
                begin
                    held_value    = s;
                    held_position = pos;
                end
                else if (s > held_value)
                begin
                    push(KIND_MIN, 1'b0);
                    held_value    = s;
                    held_position = pos;
                    rising        = 1'b1;
                end
            end

            if (last)
            begin
                push(rising ? KIND_MAX : KIND_MIN, 1'b1);
                restart();
            end
        endfunction

        function string check_extremum(extremum_t got);
            extremum_t want;
            string     diff;
            if (awaited.size() == 0)
                return $sformatf("unexpected result kind=%0d value=%0d position=%0d end=%0d",
                                 got.kind, got.value, got.position, got.seq_end);
            want = awaited.pop_front();
            diff = "";
            if (got.kind !== want.kind)
                diff = {diff, $sformatf(" kind %0d/%0d", got.kind, want.kind)};
            if (got.value !== want.value)
                diff = {diff, $sformatf(" value %0d/%0d", got.value, want.value)};
            if (got.position !== want.position)
                diff = {diff, $sformatf(" position %0d/%0d", got.position, want.position)};
            if (got.seq_end !== want.seq_end)
                diff = {diff, $sformatf(" end %0d/%0d", got.seq_end, want.seq_end)};
            if (diff != "")
                diff = {"result got/expected:", diff};
            return diff;
        endfunction
    endclass

    logic          clk;
    logic          rst_n       = 1'b0;
    logic          in_valid    = 1'b0;
    logic          in_ready;
    sample_t       sample      = '0;
    logic          last_sample = 1'b0;
    logic          out_valid;
    logic          out_ready   = 1'b0;
    logic          extremum_kind;
    sample_t       extremum_value;
    logic [PB-1:0] extremum_position;
    logic          sequence_end;

    extrema_book expected_extrema = new();
    int          errors   = 0;
    int          beats_in = 0;
    bit          no_idle  = 1'b0;

    local_extrema_tracker DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .sample            (sample),
        .last_sample       (last_sample),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .extremum_kind     (extremum_kind),
        .extremum_value    (extremum_value),
        .extremum_position (extremum_position),
        .sequence_end      (sequence_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic sample_t clamp_sample(int v);
        if (v > 32767)
            return sample_t'(32767);
        if (v < -32768)
            return sample_t'(-32768);
        return sample_t'(v);
    endfunction

    // Called at a rising edge; returns at the edge that accepts the beat.
    task automatic send_sample(sample_t s, logic last, int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        sample      <= s;
        last_sample <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_extrema.note_sample(s, last);
        beats_in++;
    endtask

    task automatic send_run(int vals[$]);
        foreach (vals[i])
            send_sample(sample_t'(vals[i]), i == vals.size() - 1, draw_wait());
    endtask

    // hold input low until the block owes nothing
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_extrema.awaited.size() != 0);
    endtask

    task automatic send_random_sequence();
        int vals[$];
        int len;
        int span;
        int v;
        int style;
        style = $urandom_range(0, 9);
        if (style <= 1)
        begin
            len = (style == 0) ? $urandom_range(1, 8) : $urandom_range(1, 2);
            repeat (len)
                vals.insert(vals.size(), int'(sample_t'($urandom)));
        end
        else
        begin
            len = $urandom_range(3, 40);
            case ($urandom_range(0, 3))
                0: span = 1;
                1: span = 4;
                2: span = 256;
                default: span = 65535;
            endcase
            v = int'(sample_t'($urandom));
            repeat (len)
            begin
                v = int'(clamp_sample(v));
                vals.insert(vals.size(), v);
                // hold the value now and then to form plateaus
                if ($urandom_range(0, 3) != 0)
                    v = v + int'($urandom_range(0, 2 * span)) - span;
            end
        end
        send_run(vals);
    endtask

    initial
    begin
        extremum_t got;
        string     diff;
        int        stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            got = '{extremum_kind, extremum_value, extremum_position, sequence_end};
            diff = expected_extrema.check_extremum(got);
            if (diff != "")
                report_mismatch(diff);
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-sample sequences at both extremes
        send_run('{32767});
        send_run('{-32768});
        // flat start counts as rising; plateau keeps the first position
        send_run('{0, 0, 0});
        // falling start, a turn on each sample after that, two results on the last
        send_run('{5, -32768, 32767, -32768});
        send_run('{-1, 3, 3, 7, 2, 2, -4, 9});
        send_run('{100, 50});
        send_run('{-32768, 32767});
        drain_results();

        while (beats_in < ITEM_TARGET)
        begin
            no_idle = ($urandom_range(0, 7) == 0);
            send_random_sequence();
            if ($urandom_range(0, 49) == 0)
                drain_results();
        end
        no_idle = 1'b0;
        in_valid <= 1'b0;

        while (expected_extrema.awaited.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== local_extrema_tracker.f =====
rtl/lext_pkg.sv
rtl/lext_core.sv
rtl/lext_queue.sv
rtl/local_extrema_tracker.sv
tb/tb.sv
